// ===== hw/rtl/pmi2c_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi2c_pkg
// Shared types and constants for the power monitor register slave core.
// ----------------------------------------------------------------------------
package pmi2c_pkg;

  // command codes
  localparam logic [1:0] CMD_START_WR = 2'd0;
  localparam logic [1:0] CMD_START_RD = 2'd1;
  localparam logic [1:0] CMD_WR_BYTE  = 2'd2;
  localparam logic [1:0] CMD_RD_BYTE  = 2'd3;

  // register pointers
  localparam logic [7:0] PTR_CONFIG = 8'h00;
  localparam logic [7:0] PTR_SHUNT  = 8'h01;
  localparam logic [7:0] PTR_BUS    = 8'h02;
  localparam logic [7:0] PTR_CALIB  = 8'h05;

  localparam logic [15:0] SOFT_RESET_WORD = 16'h8000;
  localparam logic [15:0] RAW_POS_MAX     = 16'h7FFF;
  localparam logic [15:0] RAW_NEG_MIN     = 16'h8000;

  // scaled numerator limit: 5 * 32768, quotient saturates at or above it
  localparam logic [18:0] NUM_SAT_LIMIT = 19'd163840;
  // bus millivolts at which 4/5 scaling saturates
  localparam logic [15:0] BUS_MV_LIMIT  = 16'd40960;

  // divide by 5 as multiply by ceil(2^20 / 5), exact for numerators below 2^18
  localparam logic [17:0] DIV5_RECIP = 18'd209716;
  localparam int          DIV5_SHIFT = 20;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         write_byte;
    logic [15:0]        bus_millivolts;
    logic signed [17:0] shunt_microvolts;
  } item_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] read_byte;
  } result_t;

endpackage : pmi2c_pkg
`default_nettype wire

// ===== hw/rtl/pmi2c_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi2c_scale
// Converts shunt microvolts (x2/5, signed, saturated) or bus millivolts
// (x4/5, saturated at 0x7FFF) to a 16-bit raw register value. One shared
// divide-by-five multiplier serves both conversions.
// ----------------------------------------------------------------------------
module pmi2c_scale (
  input  wire logic        sel_bus,
  input  wire logic [15:0] bus_millivolts,
  input  wire logic [17:0] shunt_microvolts,
  output logic      [15:0] raw
);
  import pmi2c_pkg::*;

  logic        neg;
  logic [17:0] mag;
  logic [18:0] num_shunt;
  logic [18:0] num_bus;
  logic [18:0] num;
  logic [35:0] prod;
  logic [14:0] quot;
  logic        sat_shunt;
  logic        sat_bus;

  always_comb begin
    neg       = shunt_microvolts[17];
    mag       = neg ? (~shunt_microvolts + 18'd1) : shunt_microvolts;
    num_shunt = {mag, 1'b0};
    num_bus   = {1'b0, bus_millivolts, 2'b00};
    sat_shunt = (num_shunt >= NUM_SAT_LIMIT);
    sat_bus   = (bus_millivolts >= BUS_MV_LIMIT);
    num       = sel_bus ? num_bus : num_shunt;
    prod      = num[17:0] * DIV5_RECIP;
    quot      = prod[DIV5_SHIFT +: 15];

    if (sel_bus) begin
      raw = sat_bus ? RAW_POS_MAX : {1'b0, quot};
    end else if (sat_shunt) begin
      raw = neg ? RAW_NEG_MIN : RAW_POS_MAX;
    end else if (neg) begin
      raw = ~{1'b0, quot} + 16'd1;
    end else begin
      raw = {1'b0, quot};
    end
  end

endmodule : pmi2c_scale
`default_nettype wire

// ===== hw/rtl/pmi2c_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi2c_exec
// Register file and transaction sequencer. Executes one registered command
// per cycle while the output is not stalled, updates pointer, write phase
// and registers, and holds the result in the output register.
// ----------------------------------------------------------------------------
module pmi2c_exec (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire pmi2c_pkg::item_t  item,
  input  wire logic              fail_mode,
  input  wire logic              out_tready,
  output logic                   item_take,
  output logic                   out_valid,
  output pmi2c_pkg::result_t     result
);
  import pmi2c_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PTR  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_LOW  = 2'd3;

  logic [7:0]  pointer_r,    pointer_nxt;
  logic [1:0]  phase_r,      phase_nxt;
  logic [7:0]  held_high_r,  held_high_nxt;
  logic [15:0] config_r,     config_nxt;
  logic [15:0] calib_r,      calib_nxt;
  logic [15:0] latch_r,      latch_nxt;
  logic        low_next_r,   low_next_nxt;
  logic        out_valid_r;
  result_t     result_r,     result_nxt;

  logic        adv;
  logic        step;
  logic [15:0] raw;
  logic [15:0] word;

  pmi2c_scale u_scale (
    .sel_bus          (pointer_r == PTR_BUS),
    .bus_millivolts   (item.bus_millivolts),
    .shunt_microvolts (item.shunt_microvolts),
    .raw              (raw)
  );

  assign adv       = !out_valid_r || out_tready;
  assign step      = item_valid && adv;
  assign item_take = adv;
  assign out_valid = out_valid_r;
  assign result    = result_r;

  always_comb begin
    pointer_nxt   = pointer_r;
    phase_nxt     = phase_r;
    held_high_nxt = held_high_r;
    config_nxt    = config_r;
    calib_nxt     = calib_r;
    latch_nxt     = latch_r;
    low_next_nxt  = low_next_r;
    result_nxt    = '{ack: 1'b1, read_byte: 8'd0};
    word          = {held_high_r, item.write_byte};

    case (item.command)
      CMD_START_WR, CMD_START_RD: begin
        if (fail_mode) begin
          result_nxt.ack = 1'b0;
        end else if (item.command == CMD_START_WR) begin
          phase_nxt = PH_PTR;
        end else begin
          low_next_nxt = 1'b0;
          case (pointer_r)
            PTR_CONFIG:         latch_nxt = config_r;
            PTR_SHUNT, PTR_BUS: latch_nxt = raw;
            PTR_CALIB:          latch_nxt = calib_r;
            default:            latch_nxt = 16'd0;
          endcase
        end
      end
      CMD_WR_BYTE: begin
        case (phase_r)
          PH_PTR: begin
            pointer_nxt = item.write_byte;
            phase_nxt   = PH_HIGH;
          end
          PH_HIGH: begin
            held_high_nxt = item.write_byte;
            phase_nxt     = PH_LOW;
          end
          PH_LOW: begin
            if (pointer_r == PTR_CONFIG) begin
              config_nxt = word;
              if (word == SOFT_RESET_WORD) begin
                calib_nxt = 16'd0;
              end
            end else if (pointer_r == PTR_CALIB) begin
              calib_nxt = word;
            end
            phase_nxt = PH_PTR;
          end
          default: ;
        endcase
      end
      default: begin
        result_nxt.read_byte = low_next_r ? latch_r[7:0] : latch_r[15:8];
        low_next_nxt         = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pointer_r   <= 8'd0;
      phase_r     <= PH_IDLE;
      held_high_r <= 8'd0;
      config_r    <= 16'd0;
      calib_r     <= 16'd0;
      latch_r     <= 16'd0;
      low_next_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        pointer_r   <= pointer_nxt;
        phase_r     <= phase_nxt;
        held_high_r <= held_high_nxt;
        config_r    <= config_nxt;
        calib_r     <= calib_nxt;
        latch_r     <= latch_nxt;
        low_next_r  <= low_next_nxt;
      end
      if (adv) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result_nxt;
    end
  end

  a_phase_no_idle_return: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |=> (phase_r != PH_IDLE))
    else $error("write phase returned to idle");

  a_read_sets_low: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.command == CMD_RD_BYTE) |=> low_next_r)
    else $error("read byte did not advance to low byte");

  a_nak_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !result_r.ack) |-> (result_r.read_byte == 8'd0))
    else $error("nak result carries data");

  a_fail_start_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && fail_mode && item.command != CMD_WR_BYTE && item.command != CMD_RD_BYTE)
    |=> ($stable(phase_r) && $stable(latch_r) && $stable(low_next_r)))
    else $error("nak start changed state");

  a_soft_reset_calib: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.command == CMD_WR_BYTE && phase_r == PH_LOW && pointer_r == PTR_CONFIG
     && word == SOFT_RESET_WORD) |=> (calib_r == 16'd0))
    else $error("soft reset did not clear calibration");

endmodule : pmi2c_exec
`default_nettype wire

// ===== hw/rtl/power_monitor_i2c_registers_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// power_monitor_i2c_registers_core
// Byte-level register side of a current and voltage monitor on a two-wire bus.
//
// in_*  : one bus event per transfer (start write, start read, write byte,
//         read byte) plus the present bus and shunt measurements.
// out_* : one result per input transfer: ack flag and returned read byte.
// cfg_* : fail mode bit, always ready; to be written only while the core is idle,
//         the core itself does not enforce this.
// An input transfer passes the input register, then execute into the result register.
// Throughput: one transfer per cycle while out_tready does not stall the result,
// set by the register update and the one divide-by-five multiplier in the scaling unit.
// Reset clears pointer, write phase, all registers, fail mode and both
// pipeline valid flags. When out_tready is low the result and the item in
// the input register hold; in_tready drops only once both stages are full.
// ----------------------------------------------------------------------------
module power_monitor_i2c_registers_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // write_byte, bus_millivolts, shunt_microvolts, pad
  input  wire logic [1:0]  in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // ack, read_byte, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // fail_mode
);
  import pmi2c_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  logic    fail_mode_r;
  logic    item_take;
  result_t result;

  assign in_tready = !in_valid_r || item_take;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      fail_mode_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (cfg_valid) begin
        fail_mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command          <= in_tuser;
      item_r.write_byte       <= in_tdata[7:0];
      item_r.bus_millivolts   <= in_tdata[23:8];
      item_r.shunt_microvolts <= in_tdata[41:24];
    end
  end

  pmi2c_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (item_r),
    .fail_mode  (fail_mode_r),
    .out_tready (out_tready),
    .item_take  (item_take),
    .out_valid  (out_tvalid),
    .result     (result)
  );

  assign out_tdata = {7'd0, result.read_byte, result.ack};

endmodule : power_monitor_i2c_registers_core
`default_nettype wire
